// ===== hw/rtl/avo_pkg.sv =====
// Shared widths, register indexes and state types for the three-axis averager.
package avo_pkg;

   // Fixed field widths
   localparam int IN_W     = 16;
   localparam int LEVEL_W  = 25;
   localparam int BASE_W   = 24;
   localparam int CNT_W    = 11;
   localparam int CSR_ADDR_W = 2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_COUNT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CALIBRATE_MODE = 2'd1;

   // Axis sequencing in the back end
   localparam logic [1:0] AXIS_FIRST = 2'd0;
   localparam logic [1:0] AXIS_LAST  = 2'd2;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage

// ===== hw/rtl/avo_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module avo_div #(
   parameter int DIV_W  = 35,
   parameter int DVSR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVSR_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              ge;

   // Trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, dvsr_ff};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CW'(DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/avo_queue.sv =====
// Two-entry queue of closed blocks between the accumulator and the divide back end.
module avo_queue #(
   parameter int WIDTH = 90
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/avo_front.sv =====
// Front end: accepts samples, accumulates three sums and closes blocks into the queue.
module avo_front #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SUM_W       = 26,
   parameter int Q_W         = 3 * 26 + 11 + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_fire,
   input  logic [avo_pkg::IN_W-1:0] accel_x,
   input  logic [avo_pkg::IN_W-1:0] accel_y,
   input  logic [avo_pkg::IN_W-1:0] accel_z,
   input  logic [avo_pkg::CNT_W-1:0] sample_count,
   input  logic                     calibrate_mode,
   output logic                     push,
   output logic [Q_W-1:0]           push_data
);

   localparam int CNT_W = avo_pkg::CNT_W;

   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [SUM_W-1:0] sum_x_in, sum_y_in, sum_z_in;
   logic [CNT_W-1:0]        taken_ff, taken_in;
   logic [CNT_W-1:0]        n_eff;
   logic signed [avo_pkg::IN_W-1:0] x_s, y_s, z_s;
   logic                    close;

   assign x_s = accel_x;
   assign y_s = accel_y;
   assign z_s = accel_z;

   // Effective block length: zero acts as one, clamp at the maximum
   always_comb begin
      if (sample_count == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(sample_count) > 32'(MAX_SAMPLES)) begin
         n_eff = CNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = sample_count;
      end
   end

   // Accumulate and detect the end of a block
   assign sum_x_in = sum_x_ff + SUM_W'(x_s);
   assign sum_y_in = sum_y_ff + SUM_W'(y_s);
   assign sum_z_in = sum_z_ff + SUM_W'(z_s);
   assign taken_in = taken_ff + 1'b1;
   assign close    = taken_in >= n_eff;

   assign push      = req_fire && close;
   assign push_data = {calibrate_mode, n_eff, sum_z_in, sum_y_in, sum_x_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         taken_ff <= '0;
      end else if (req_fire) begin
         if (close) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            sum_z_ff <= '0;
            taken_ff <= '0;
         end else begin
            sum_x_ff <= sum_x_in;
            sum_y_ff <= sum_y_in;
            sum_z_ff <= sum_z_in;
            taken_ff <= taken_in;
         end
      end
   end

endmodule

// ===== hw/rtl/avo_back.sv =====
// Back end: divides each sum, applies or stores the baseline, holds the result register.
module avo_back #(
   parameter int SUM_W     = 26,
   parameter int FRAC_BITS = 8,
   parameter int Q_W       = 3 * 26 + 11 + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  logic [Q_W-1:0]               q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [avo_pkg::LEVEL_W-1:0]  level_x,
   output logic [avo_pkg::LEVEL_W-1:0]  level_y,
   output logic [avo_pkg::LEVEL_W-1:0]  level_z,
   output logic                         is_baseline
);

   localparam int CNT_W   = avo_pkg::CNT_W;
   localparam int LEVEL_W = avo_pkg::LEVEL_W;
   localparam int BASE_W  = avo_pkg::BASE_W;
   localparam int DIV_W   = SUM_W + FRAC_BITS + 1;
   localparam int DVSR_W  = CNT_W + 1;

   avo_pkg::back_state_type state_ff, state_in;

   logic signed [SUM_W-1:0]   job_sum_ff [3];
   logic [CNT_W-1:0]          job_n_ff;
   logic                      job_mode_ff;
   logic [1:0]                axis_ff;
   logic                      neg_ff;
   logic signed [LEVEL_W-1:0] avg_ff [3];
   logic signed [BASE_W-1:0]  base_ff [3];
   logic [LEVEL_W-1:0]        lvl_ff [3];
   logic                      is_base_ff;
   logic                      rsp_valid_ff;

   logic                      div_start, div_done;
   logic [DIV_W-1:0]          dividend, quotient;
   logic signed [SUM_W-1:0]   cur_sum;
   logic [SUM_W-1:0]          mag;
   logic                      cur_neg;
   logic [LEVEL_W-1:0]        q_low;
   logic                      out_load;
   logic                      out_free;

   // Sign and magnitude of the axis sum, scaled numerator with half-step rounding
   assign cur_sum  = job_sum_ff[axis_ff];
   assign cur_neg  = cur_sum[SUM_W-1];
   assign mag      = cur_neg ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
   assign dividend = (DIV_W'(mag) << (FRAC_BITS + 1)) + DIV_W'(job_n_ff);
   assign q_low    = quotient[LEVEL_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   avo_div #(
      .DIV_W  (DIV_W),
      .DVSR_W (DVSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  ({job_n_ff, 1'b0}),
      .done     (div_done),
      .quotient (quotient)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         avo_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = avo_pkg::BK_LOAD;
            end
         end
         avo_pkg::BK_LOAD: state_in = avo_pkg::BK_DIV;
         avo_pkg::BK_DIV: begin
            if (div_done) begin
               state_in = (axis_ff == avo_pkg::AXIS_LAST) ? avo_pkg::BK_OUT
                                                          : avo_pkg::BK_LOAD;
            end
         end
         avo_pkg::BK_OUT: begin
            if (out_free) begin
               state_in = avo_pkg::BK_IDLE;
            end
         end
         default: state_in = avo_pkg::BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         avo_pkg::BK_IDLE: q_pop     = q_valid;
         avo_pkg::BK_LOAD: div_start = 1'b1;
         avo_pkg::BK_DIV:  ;
         avo_pkg::BK_OUT:  out_load  = out_free;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= avo_pkg::BK_IDLE;
         axis_ff      <= avo_pkg::AXIS_FIRST;
         rsp_valid_ff <= 1'b0;
         base_ff[0]   <= '0;
         base_ff[1]   <= '0;
         base_ff[2]   <= '0;
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            axis_ff <= avo_pkg::AXIS_FIRST;
         end else if (state_ff == avo_pkg::BK_DIV && div_done) begin
            axis_ff <= axis_ff + 2'd1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_load && job_mode_ff) begin
            for (int i = 0; i < 3; i++) begin
               base_ff[i] <= avg_ff[i][BASE_W-1:0];
            end
         end
      end
   end

   // Job, quotient and result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_sum_ff[0] <= q_data[SUM_W-1:0];
         job_sum_ff[1] <= q_data[2*SUM_W-1:SUM_W];
         job_sum_ff[2] <= q_data[3*SUM_W-1:2*SUM_W];
         job_n_ff      <= q_data[3*SUM_W+CNT_W-1:3*SUM_W];
         job_mode_ff   <= q_data[3*SUM_W+CNT_W];
      end
      if (div_start) begin
         neg_ff <= cur_neg;
      end
      if (state_ff == avo_pkg::BK_DIV && div_done) begin
         avg_ff[axis_ff] <= neg_ff ? -q_low : q_low;
      end
      if (out_load) begin
         is_base_ff <= job_mode_ff;
         for (int i = 0; i < 3; i++) begin
            lvl_ff[i] <= job_mode_ff ? avg_ff[i] : avg_ff[i] - LEVEL_W'(base_ff[i]);
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign level_x     = lvl_ff[0];
   assign level_y     = lvl_ff[1];
   assign level_z     = lvl_ff[2];
   assign is_baseline = is_base_ff;

endmodule

// ===== hw/rtl/three_axis_average_offset_unit.sv =====
// Top level of the three-axis block averager with offset calibration.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata: accel_x, accel_y, accel_z
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: level_x/y/z, tuser: is_baseline
//  csr     | in        | csr_we                | csr_addr, csr_wdata
//
// The accumulator takes one sample per cycle while the block queue (two entries) has room.
// Each closed block passes through the back end, which uses the single shared bit-serial
// divider to handle the three axes in turn.
// Synchronous reset clears sums, counter, baseline, queue and the result valid flag.
// A stalled result holds in the output register while sampling continues up to the queue.
module three_axis_average_offset_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int FRAC_BITS   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,  // accel_x, accel_y, accel_z
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [79:0]                     rsp_tdata,  // level_x, level_y, level_z, zero pad
   output logic                            rsp_tuser,  // is_baseline
   input  logic                            csr_we,
   input  logic [avo_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [avo_pkg::CNT_W-1:0]       csr_wdata
);

   localparam int IN_W    = avo_pkg::IN_W;
   localparam int LEVEL_W = avo_pkg::LEVEL_W;
   localparam int CNT_W   = avo_pkg::CNT_W;
   localparam int SUM_W   = IN_W + $clog2(MAX_SAMPLES);
   localparam int Q_W     = 3 * SUM_W + CNT_W + 1;

   logic [CNT_W-1:0]   sample_count_ff;
   logic               calibrate_mode_ff;
   logic               req_fire;
   logic               q_push, q_full, q_pop, q_valid;
   logic [Q_W-1:0]     q_push_data, q_pop_data;
   logic [LEVEL_W-1:0] level_x, level_y, level_z;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff   <= CNT_W'(1);
         calibrate_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            avo_pkg::CSR_SAMPLE_COUNT:   sample_count_ff   <= csr_wdata;
            avo_pkg::CSR_CALIBRATE_MODE: calibrate_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign req_fire   = req_tvalid && req_tready;

   avo_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SUM_W       (SUM_W),
      .Q_W         (Q_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .accel_x        (req_tdata[IN_W-1:0]),
      .accel_y        (req_tdata[2*IN_W-1:IN_W]),
      .accel_z        (req_tdata[3*IN_W-1:2*IN_W]),
      .sample_count   (sample_count_ff),
      .calibrate_mode (calibrate_mode_ff),
      .push           (q_push),
      .push_data      (q_push_data)
   );

   avo_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   avo_back #(
      .SUM_W     (SUM_W),
      .FRAC_BITS (FRAC_BITS),
      .Q_W       (Q_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .level_x     (level_x),
      .level_y     (level_y),
      .level_z     (level_z),
      .is_baseline (rsp_tuser)
   );

   assign rsp_tdata = {5'b0, level_z, level_y, level_x};

endmodule
